// ===== design/shab_pkg.sv =====
package shab_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned ROUNDS   = 80;

  localparam logic [1:0] FUNC_ABSORB  = 2'd0;
  localparam logic [1:0] FUNC_FINISH  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SEQ_ERR  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LEN_START     = 6'd55;
  localparam logic [5:0] BLOCK_END     = 6'd63;
  localparam logic [6:0] LAST_ROUND    = 7'd79;

  localparam logic [WORD_W-1:0] INIT_WORDS [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } shab_vars_t;

  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic       expand;
    logic [7:0] byte_val;
  } sched_ctl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_const(input logic [6:0] rnd);
    logic [WORD_W-1:0] k;
    priority if (rnd < 7'd20) k = 32'h5A827999;
    else if (rnd < 7'd40)     k = 32'h6ED9EBA1;
    else if (rnd < 7'd60)     k = 32'h8F1BBCDC;
    else                      k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

// ===== design/shab_ifs.sv =====
interface shab_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface shab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, output digest_word, output word_index, output last,
                  output status, input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  input status, output ready);
endinterface

// ===== design/shab_round.sv =====
module shab_round (
  input  logic [6:0]              rnd,
  input  shab_pkg::shab_vars_t    cur,
  input  logic [31:0]             w,
  output shab_pkg::shab_vars_t    nxt
);
  import shab_pkg::*;

  logic [WORD_W-1:0] f;

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
    end
  end

  always_comb begin
    nxt.a = rotl(cur.a, 5) + f + cur.e + w + round_const(rnd);
    nxt.b = cur.a;
    nxt.c = rotl(cur.b, 30);
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ===== design/shab_sched.sv =====
module shab_sched (
  input  logic                 clk,
  input  shab_pkg::sched_ctl_t ctl,
  output logic [31:0]          w
);
  import shab_pkg::*;

  // [15] holds the oldest word, [0] the newest
  logic [15:0][WORD_W-1:0] win_r;
  logic [15:0][WORD_W-1:0] win_nxt;

  always_comb begin
    if (ctl.expand) begin
      w = rotl(win_r[2] ^ win_r[7] ^ win_r[13] ^ win_r[15], 1);
    end else begin
      w = win_r[15];
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (ctl.shift_word) begin
      win_nxt = {win_r[14:0], w};
    end else if (ctl.shift_byte) begin
      win_nxt = {win_r[15][23:0], win_r[14:0], ctl.byte_val};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ===== design/sha1_byte_stream_hasher.sv =====
// SHA-1 over a byte stream. A data byte is taken per input transfer; every 64th byte
// starts a compression of 80 rounds on one shared round unit, one round per cycle,
// and then folds the result into the chaining value. Finish shifts padding and the
// 8 length bytes through the block register one byte per cycle, runs one or two
// compressions, and then hands out five digest words, one transfer each. The input
// is not ready while padding, compressing, folding or emitting. A repeated finish
// re-emits the digest; data after finish yields an error result, and so does each
// data or finish item after an error or a wrapped bit count, until restart.
module sha1_byte_stream_hasher (
  input logic       clk,
  input logic       rst_n,
  shab_in_if.sink   in_chan,
  shab_out_if.source out_chan
);
  import shab_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_COMP = 6'b001000,
    ST_FOLD = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [5:0]                   fill_r, fill_nxt;
  logic [63:0]                  bitlen_r, bitlen_nxt;
  logic                         finished_r, finished_nxt;
  logic [1:0]                   err_r, err_nxt;
  logic                         first_r, first_nxt;
  logic                         pad_r, pad_nxt;
  logic                         final_r, final_nxt;
  logic [6:0]                   rnd_r, rnd_nxt;
  logic [2:0]                   emit_cnt_r, emit_cnt_nxt;
  logic                         emit_err_r, emit_err_nxt;
  logic [NUM_WORDS-1:0][31:0]   chain_r, chain_nxt;
  shab_vars_t                   vars_r, vars_nxt, round_out;

  logic                         out_valid_r, out_valid_nxt;
  logic [31:0]                  out_word_r, out_word_nxt;
  logic [2:0]                   out_idx_r, out_idx_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;

  sched_ctl_t                   sched_ctl;
  logic [31:0]                  w;
  logic                         in_xfer;
  logic                         out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  shab_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w)
  );

  shab_round u_round (
    .rnd (rnd_r),
    .cur (vars_r),
    .w   (w),
    .nxt (round_out)
  );

  function automatic shab_vars_t chain_to_vars(input logic [NUM_WORDS-1:0][31:0] cv);
    shab_vars_t v;
    v.a = cv[0];
    v.b = cv[1];
    v.c = cv[2];
    v.d = cv[3];
    v.e = cv[4];
    return v;
  endfunction

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    bitlen_nxt   = bitlen_r;
    finished_nxt = finished_r;
    err_nxt      = err_r;
    first_nxt    = first_r;
    pad_nxt      = pad_r;
    final_nxt    = final_r;
    rnd_nxt      = rnd_r;
    emit_cnt_nxt = emit_cnt_r;
    emit_err_nxt = emit_err_r;
    chain_nxt    = chain_r;
    vars_nxt     = vars_r;

    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_word_nxt   = out_word_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    sched_ctl = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_chan.func)
            FUNC_ABSORB: begin
              if (finished_r) begin
                err_nxt      = STATUS_SEQ_ERR;
                emit_err_nxt = 1'b1;
                state_nxt    = ST_EMIT;
              end else if (err_r != STATUS_OK) begin
                emit_err_nxt = 1'b1;
                state_nxt    = ST_EMIT;
              end else begin
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.byte_val   = in_chan.data_byte;
                fill_nxt             = fill_r + 6'd1;
                bitlen_nxt           = bitlen_r + 64'd8;
                if (bitlen_nxt == 64'd0) begin
                  err_nxt = STATUS_TOO_LONG;
                end
                if (fill_r == BLOCK_END) begin
                  vars_nxt  = chain_to_vars(chain_r);
                  rnd_nxt   = '0;
                  state_nxt = ST_COMP;
                end
              end
            end
            FUNC_FINISH: begin
              if (err_r != STATUS_OK) begin
                emit_err_nxt = 1'b1;
                state_nxt    = ST_EMIT;
              end else if (finished_r) begin
                emit_err_nxt = 1'b0;
                emit_cnt_nxt = '0;
                state_nxt    = ST_EMIT;
              end else begin
                first_nxt = 1'b1;
                pad_nxt   = 1'b1;
                state_nxt = ST_PAD;
              end
            end
            FUNC_RESTART: begin
              chain_nxt    = {INIT_WORDS[4], INIT_WORDS[3], INIT_WORDS[2],
                              INIT_WORDS[1], INIT_WORDS[0]};
              fill_nxt     = '0;
              bitlen_nxt   = '0;
              finished_nxt = 1'b0;
              err_nxt      = STATUS_OK;
            end
            default: begin
              // unused code: drop the item
            end
          endcase
        end
      end

      ST_PAD: begin
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_val   = first_r ? PAD_MARK : 8'h00;
        first_nxt            = 1'b0;
        fill_nxt             = fill_r + 6'd1;
        if (fill_r == BLOCK_END) begin
          vars_nxt  = chain_to_vars(chain_r);
          rnd_nxt   = '0;
          state_nxt = ST_COMP;
        end else if (fill_r == LEN_START) begin
          state_nxt = ST_LEN;
        end
      end

      ST_LEN: begin
        // shift the bit count out MSB first; this also clears it
        sched_ctl.shift_byte = 1'b1;
        sched_ctl.byte_val   = bitlen_r[63:56];
        bitlen_nxt           = {bitlen_r[55:0], 8'h00};
        fill_nxt             = fill_r + 6'd1;
        if (fill_r == BLOCK_END) begin
          final_nxt = 1'b1;
          vars_nxt  = chain_to_vars(chain_r);
          rnd_nxt   = '0;
          state_nxt = ST_COMP;
        end
      end

      ST_COMP: begin
        sched_ctl.shift_word = 1'b1;
        sched_ctl.expand     = (rnd_r >= 7'd16);
        vars_nxt             = round_out;
        rnd_nxt              = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        chain_nxt[0] = chain_r[0] + vars_r.a;
        chain_nxt[1] = chain_r[1] + vars_r.b;
        chain_nxt[2] = chain_r[2] + vars_r.c;
        chain_nxt[3] = chain_r[3] + vars_r.d;
        chain_nxt[4] = chain_r[4] + vars_r.e;
        if (final_r) begin
          final_nxt    = 1'b0;
          pad_nxt      = 1'b0;
          finished_nxt = 1'b1;
          emit_err_nxt = 1'b0;
          emit_cnt_nxt = '0;
          state_nxt    = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (emit_err_r) begin
            out_word_nxt   = '0;
            out_idx_nxt    = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = err_r;
            state_nxt      = ST_IDLE;
          end else begin
            out_word_nxt   = chain_r[emit_cnt_r];
            out_idx_nxt    = emit_cnt_r;
            out_last_nxt   = (emit_cnt_r == LAST_WORD_IDX);
            out_status_nxt = STATUS_OK;
            emit_cnt_nxt   = emit_cnt_r + 3'd1;
            if (emit_cnt_r == LAST_WORD_IDX) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bitlen_r    <= '0;
      finished_r  <= 1'b0;
      err_r       <= STATUS_OK;
      first_r     <= 1'b0;
      pad_r       <= 1'b0;
      final_r     <= 1'b0;
      rnd_r       <= '0;
      emit_cnt_r  <= '0;
      emit_err_r  <= 1'b0;
      chain_r     <= {INIT_WORDS[4], INIT_WORDS[3], INIT_WORDS[2],
                      INIT_WORDS[1], INIT_WORDS[0]};
      vars_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      finished_r  <= finished_nxt;
      err_r       <= err_nxt;
      first_r     <= first_nxt;
      pad_r       <= pad_nxt;
      final_r     <= final_nxt;
      rnd_r       <= rnd_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      emit_err_r  <= emit_err_nxt;
      chain_r     <= chain_nxt;
      vars_r      <= vars_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.last        = out_last_r;
  assign out_chan.status      = out_status_r;

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == LAST_ROUND) |=> (state_r == ST_FOLD))
    else $error("compression did not fold after the last round");

  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && state_r == ST_IDLE) |-> (bitlen_r == 64'd0 && fill_r == 6'd0))
    else $error("bit count or fill left over after finish");

  a_finish_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> ($past(state_r) == ST_FOLD))
    else $error("finished set outside the final fold");

  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && out_status_r == STATUS_OK)
      |-> (out_idx_r == LAST_WORD_IDX))
    else $error("digest run ended before the last word");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK)
      |-> (out_word_r == 32'd0 && out_idx_r == 3'd0 && out_last_r))
    else $error("error result is not shaped as a single zero word");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import shab_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [WORD_W-1:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        index;
    logic              last;
    logic [1:0]        status;
  } digest_res_t;

  logic clk = 1'b0;
  logic rst_n;

  shab_in_if  in_chan ();
  shab_out_if out_chan ();

  sha1_byte_stream_hasher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hash state tracked alongside the block
  logic [WORD_W-1:0] chain_h [NUM_WORDS];
  logic [7:0]        msg_block [64];
  int unsigned       pend_bytes;
  logic [63:0]       msg_bits;
  logic              digest_done;
  logic [1:0]        sticky_err;

  digest_res_t digest_q [$];
  digest_res_t got_res;
  digest_res_t want_res;

  int unsigned mismatches;
  int unsigned accepted_items;
  int unsigned burst_left;
  int unsigned idle_cycles;
  logic [15:0] stall_pat;
  logic [5:0]  pat_age;

  function automatic void hasher_clear();
    for (int i = 0; i < NUM_WORDS; i++) chain_h[i] = INIT_WORDS[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    pend_bytes  = 0;
    msg_bits    = '0;
    digest_done = 1'b0;
    sticky_err  = STATUS_OK;
  endfunction

  function automatic void compress_msg_block();
    logic [WORD_W-1:0] w [16];
    logic [WORD_W-1:0] a, b, c, d, e, f, wt, tmp;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      end else begin
        tmp = w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[r%16];
        wt  = {tmp[30:0], tmp[31]};
      end
      w[r%16] = wt;
      if (r < 20)
        f = (b & c) | (~b & d);
      else if (r < 40 || r >= 60)
        f = b ^ c ^ d;
      else
        f = (b & c) | (b & d) | (c & d);
      tmp = {a[26:0], a[31:27]} + f + e + wt + K_ROUND[r/20];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
    pend_bytes = 0;
  endfunction

  function automatic void push_error(input logic [1:0] code);
    digest_q.push_back('{word: '0, index: 3'd0, last: 1'b1, status: code});
  endfunction

  function automatic void predict_item(input logic [1:0] fn, input logic [7:0] data_b);
    int unsigned idx;
    case (fn)
      FUNC_ABSORB: begin
        if (digest_done) begin
          sticky_err = STATUS_SEQ_ERR;
          push_error(STATUS_SEQ_ERR);
        end else if (sticky_err != STATUS_OK) begin
          push_error(sticky_err);
        end else begin
          msg_block[pend_bytes % 64] = data_b;
          pend_bytes = pend_bytes % 64 + 1;
          msg_bits += 64'd8;
          if (msg_bits == '0) sticky_err = STATUS_TOO_LONG;
          if (pend_bytes == 64) compress_msg_block();
        end
      end
      FUNC_FINISH: begin
        if (sticky_err != STATUS_OK) begin
          push_error(sticky_err);
        end else begin
          if (!digest_done) begin
            idx = pend_bytes % 64;
            msg_block[idx] = PAD_MARK;
            idx++;
            // no room for the length field: spill into a second block
            if (idx > 56) begin
              while (idx < 64) begin
                msg_block[idx] = 8'h00;
                idx++;
              end
              compress_msg_block();
              idx = 0;
            end
            while (idx < 56) begin
              msg_block[idx] = 8'h00;
              idx++;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
            compress_msg_block();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
            msg_bits    = '0;
            digest_done = 1'b1;
          end
          for (int k = 0; k < NUM_WORDS; k++)
            digest_q.push_back('{word: chain_h[k], index: 3'(k),
                                 last: (3'(k) == LAST_WORD_IDX), status: STATUS_OK});
        end
      end
      FUNC_RESTART: begin
        hasher_clear();
      end
      default: begin
      end
    endcase
  endfunction

  // Drive one item, holding it until the transfer; bursts alternate with gaps
  task automatic send_item(input logic [1:0] fn, input logic [7:0] data_b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.func      <= fn;
    in_chan.data_byte <= data_b;
    do @(posedge clk); while (!in_chan.ready);
    predict_item(fn, data_b);
    if (fn != FUNC_UNUSED) accepted_items++;
  endtask

  task automatic test_known_digests();
    send_item(FUNC_FINISH, 8'h00);   // empty message
    send_item(FUNC_RESTART, 8'h00);
    send_item(FUNC_ABSORB, 8'h61);   // "abc"
    send_item(FUNC_ABSORB, 8'h62);
    send_item(FUNC_ABSORB, 8'h63);
    send_item(FUNC_FINISH, 8'hFF);
    send_item(FUNC_RESTART, 8'hFF);
    send_item(FUNC_ABSORB, 8'h00);
    send_item(FUNC_ABSORB, 8'hFF);
    send_item(FUNC_FINISH, 8'h00);
  endtask

  task automatic test_repeat_finish();
    send_item(FUNC_FINISH, 8'h3C);
  endtask

  task automatic test_sequence_errors();
    send_item(FUNC_ABSORB, 8'h5A);   // data after finish
    send_item(FUNC_ABSORB, 8'hA5);   // error already pending
    send_item(FUNC_FINISH, 8'h00);
  endtask

  task automatic test_restart_and_unused();
    send_item(FUNC_RESTART, 8'h00);
    send_item(FUNC_UNUSED, 8'hFF);
    send_item(FUNC_ABSORB, 8'h12);
    send_item(FUNC_UNUSED, 8'h00);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_RESTART, 8'h00);
  endtask

  task automatic test_random_messages();
    logic [7:0]  edge_lens [8] = '{8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120};
    int unsigned stop_at;
    int unsigned len;
    stop_at = accepted_items + RANDOM_ITEMS;
    while (accepted_items < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(FUNC_RESTART, 8'($urandom));
        if ($urandom_range(0, 4) == 0)
          len = edge_lens[$urandom_range(0, 7)];
        else
          len = $urandom_range(0, 24);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) send_item(FUNC_UNUSED, 8'($urandom));
          send_item(FUNC_ABSORB, 8'($urandom));
        end
        send_item(FUNC_FINISH, 8'($urandom));
        if ($urandom_range(0, 2) == 0) send_item(FUNC_FINISH, 8'($urandom));
      end else begin
        // noise: any function in any order
        repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    in_chan.valid <= 1'b0;
  endtask

  // Result receiver: ready follows a rotating stall pattern, renewed when the age counter wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_pat      <= '1;
      pat_age        <= '0;
    end else begin
      out_chan.ready <= stall_pat[0];
      pat_age        <= pat_age + 6'd1;
      if (pat_age == '1) begin
        if ($urandom_range(0, 3) == 0)
          stall_pat <= '1;
        else
          stall_pat <= 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_res = '{word: out_chan.digest_word, index: out_chan.word_index,
                  last: out_chan.last, status: out_chan.status};
      if (digest_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result word=%h index=%0d last=%0b status=%0d",
                   $realtime, got_res.word, got_res.index, got_res.last, got_res.status);
        mismatches++;
      end else begin
        want_res = digest_q.pop_front();
        if (got_res !== want_res) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch exp word=%h index=%0d last=%0b status=%0d, got word=%h index=%0d last=%0b status=%0d",
                     $realtime, want_res.word, want_res.index, want_res.last,
                     want_res.status, got_res.word, got_res.index, got_res.last,
                     got_res.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.func      = FUNC_ABSORB;
    in_chan.data_byte = 8'h00;
    rst_n             = 1'b0;
    accepted_items    = 0;
    burst_left        = 0;
    hasher_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_known_digests();
    test_repeat_finish();
    test_sequence_errors();
    test_restart_and_unused();
    test_random_messages();

    // drain outstanding digest words, then let the block settle
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
